// ----- rtl/cspd_pkg.sv -----
package cspd_pkg;

   // signal format and gain format
   localparam int FRAC_BITS = 8;
   localparam int GAIN_BITS = 8;

   // shared multiplier: 32-bit signal times 17-bit signed coefficient
   localparam int PROD_W = 49;
   localparam int ACC_W  = 52;

   // fixed coefficients, round(c * 2^FRAC_BITS) with halves up
   localparam logic signed [16:0] COEF_04  = 17'(((2 << FRAC_BITS) + 2) / 5);
   localparam logic signed [16:0] COEF_03  = 17'(((3 << FRAC_BITS) + 5) / 10);
   localparam logic signed [16:0] COEF_02  = 17'(((1 << FRAC_BITS) + 2) / 5);
   localparam logic signed [16:0] COEF_01  = 17'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic signed [16:0] COEF_06  = 17'(((3 << FRAC_BITS) + 2) / 5);
   localparam logic signed [16:0] COEF_08  = 17'(((4 << FRAC_BITS) + 2) / 5);
   localparam logic signed [16:0] COEF_015 = 17'(((3 << FRAC_BITS) + 10) / 20);
   localparam logic signed [16:0] COEF_005 = 17'(((1 << FRAC_BITS) + 10) / 20);
   localparam logic signed [16:0] COEF_ONE  = 17'sd1;
   localparam logic signed [16:0] COEF_MONE = -17'sd1;

   localparam logic signed [13:0] DRIVE_MAX = 14'sd6000;
   localparam logic signed [13:0] DRIVE_MIN = -14'sd6000;

   // register indexes
   localparam logic [2:0] CSR_OUTER_KP    = 3'd0;
   localparam logic [2:0] CSR_OUTER_KD    = 3'd1;
   localparam logic [2:0] CSR_INNER_KP    = 3'd2;
   localparam logic [2:0] CSR_INNER_KD    = 3'd3;
   localparam logic [2:0] CSR_INNER_SCALE = 3'd4;

   // operand sources
   localparam logic [3:0] SRC_RAW   = 4'd0;
   localparam logic [3:0] SRC_H0    = 4'd1;
   localparam logic [3:0] SRC_H1    = 4'd2;
   localparam logic [3:0] SRC_H2    = 4'd3;
   localparam logic [3:0] SRC_D0    = 4'd4;
   localparam logic [3:0] SRC_D1    = 4'd5;
   localparam logic [3:0] SRC_S     = 4'd6;
   localparam logic [3:0] SRC_SLOPE = 4'd7;
   localparam logic [3:0] SRC_T     = 4'd8;
   localparam logic [3:0] SRC_V     = 4'd9;
   localparam logic [3:0] SRC_PREV  = 4'd10;
   localparam logic [3:0] SRC_SETP  = 4'd11;

   // coefficient selects
   localparam logic [3:0] CF_04    = 4'd0;
   localparam logic [3:0] CF_03    = 4'd1;
   localparam logic [3:0] CF_02    = 4'd2;
   localparam logic [3:0] CF_01    = 4'd3;
   localparam logic [3:0] CF_06    = 4'd4;
   localparam logic [3:0] CF_08    = 4'd5;
   localparam logic [3:0] CF_015   = 4'd6;
   localparam logic [3:0] CF_005   = 4'd7;
   localparam logic [3:0] CF_ONE   = 4'd8;
   localparam logic [3:0] CF_MONE  = 4'd9;
   localparam logic [3:0] CF_KP    = 4'd10;
   localparam logic [3:0] CF_KD    = 4'd11;
   localparam logic [3:0] CF_SCALE = 4'd12;

   // rounding shift applied to a finished sum
   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_FRAC = 2'd1;
   localparam logic [1:0] SH_GAIN = 2'd2;

   // where a finished sum goes
   localparam logic [2:0] DST_S         = 3'd0;
   localparam logic [2:0] DST_SLOPE     = 3'd1;
   localparam logic [2:0] DST_T         = 3'd2;
   localparam logic [2:0] DST_V         = 3'd3;
   localparam logic [2:0] DST_OUTER_END = 3'd4;
   localparam logic [2:0] DST_INNER_END = 3'd5;

   typedef struct packed {
      logic       first;
      logic       last;
      logic [1:0] shift;
   } mac_ctl_type;

   typedef struct packed {
      logic [3:0] src;
      logic [3:0] coef;
      logic       first;
      logic       last;
      logic [1:0] shift;
      logic [2:0] dest;
   } ucode_type;

   // one product term per entry; command 0 outer loop, command 1 inner loop
   function automatic ucode_type cspd_ucode(input logic cmd, input logic [3:0] pc);
      ucode_type u;
      u = '{SRC_T, CF_ONE, 1'b1, 1'b1, SH_NONE, DST_T};
      if (!cmd) begin
         case (pc)
            4'd0:  u = '{SRC_RAW,   CF_04,   1'b1, 1'b0, SH_FRAC, DST_S};
            4'd1:  u = '{SRC_H0,    CF_03,   1'b0, 1'b0, SH_FRAC, DST_S};
            4'd2:  u = '{SRC_H1,    CF_02,   1'b0, 1'b0, SH_FRAC, DST_S};
            4'd3:  u = '{SRC_H2,    CF_01,   1'b0, 1'b1, SH_FRAC, DST_S};
            4'd4:  u = '{SRC_S,     CF_ONE,  1'b1, 1'b0, SH_NONE, DST_SLOPE};
            4'd5:  u = '{SRC_H2,    CF_MONE, 1'b0, 1'b1, SH_NONE, DST_SLOPE};
            4'd6:  u = '{SRC_SLOPE, CF_06,   1'b1, 1'b0, SH_FRAC, DST_T};
            4'd7:  u = '{SRC_D0,    CF_03,   1'b0, 1'b0, SH_FRAC, DST_T};
            4'd8:  u = '{SRC_D1,    CF_01,   1'b0, 1'b1, SH_FRAC, DST_T};
            4'd9:  u = '{SRC_S,     CF_KP,   1'b1, 1'b0, SH_GAIN, DST_T};
            4'd10: u = '{SRC_T,     CF_KD,   1'b0, 1'b1, SH_GAIN, DST_T};
            4'd11: u = '{SRC_T,     CF_MONE, 1'b1, 1'b1, SH_NONE, DST_OUTER_END};
            default: u = '{SRC_T, CF_MONE, 1'b1, 1'b1, SH_NONE, DST_OUTER_END};
         endcase
      end else begin
         case (pc)
            4'd0:  u = '{SRC_SETP,  CF_ONE,   1'b1, 1'b0, SH_NONE, DST_S};
            4'd1:  u = '{SRC_RAW,   CF_MONE,  1'b0, 1'b1, SH_NONE, DST_S};
            4'd2:  u = '{SRC_S,     CF_ONE,   1'b1, 1'b0, SH_NONE, DST_SLOPE};
            4'd3:  u = '{SRC_H2,    CF_MONE,  1'b0, 1'b1, SH_NONE, DST_SLOPE};
            4'd4:  u = '{SRC_SLOPE, CF_08,    1'b1, 1'b0, SH_FRAC, DST_T};
            4'd5:  u = '{SRC_D0,    CF_015,   1'b0, 1'b0, SH_FRAC, DST_T};
            4'd6:  u = '{SRC_D1,    CF_005,   1'b0, 1'b1, SH_FRAC, DST_T};
            4'd7:  u = '{SRC_S,     CF_KP,    1'b1, 1'b0, SH_GAIN, DST_T};
            4'd8:  u = '{SRC_T,     CF_KD,    1'b0, 1'b1, SH_GAIN, DST_T};
            4'd9:  u = '{SRC_T,     CF_SCALE, 1'b1, 1'b1, SH_GAIN, DST_V};
            4'd10: u = '{SRC_V,     CF_08,    1'b1, 1'b0, SH_FRAC, DST_T};
            4'd11: u = '{SRC_PREV,  CF_02,    1'b0, 1'b1, SH_FRAC, DST_T};
            4'd12: u = '{SRC_T,     CF_ONE,   1'b1, 1'b1, SH_FRAC, DST_INNER_END};
            default: u = '{SRC_T, CF_ONE, 1'b1, 1'b1, SH_FRAC, DST_INNER_END};
         endcase
      end
      return u;
   endfunction

endpackage

// ----- rtl/cascaded_steering_pd_controller.sv -----
// cascaded steering pd controller, fixed point Q.8 signals, Q8.8 gains
//
// request channel (req_valid/req_ready): req_command 0 runs the outer loop on
// req_line_error and updates the yaw-rate setpoint; req_command 1 runs the inner
// loop on req_yaw_rate and updates the steering drive. each request transfer
// yields exactly one response transfer (rsp_valid/rsp_ready) carrying the
// current drive and setpoint.
// config port: csr_wr_en writes csr_wdata into register csr_index;
// indexes past inner_scale are dropped. write only while idle.
//
// all products go through one shared 32x17 multiply-accumulate unit with
// three pipeline stages (product, accumulate, round/saturate) under a
// microcode sequencer, which issues the terms of each group and waits for
// its finished sum before it issues the next group. a request is taken only
// after the previous one has been committed and handed to the response
// register. req_ready is high only while idle.
// the response sits in its own output register: if the receiver stalls, the
// next request is taken, computed and committed, then the sequencer holds in
// done until the held response has been taken.
// reset (synchronous) clears all loop history and restores default gains.
module cascaded_steering_pd_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic signed [15:0] req_line_error,
   input  logic signed [15:0] req_yaw_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [13:0] rsp_steer_drive,
   output logic signed [31:0] rsp_yaw_setpoint,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import cspd_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // gain registers
   logic [15:0] outer_kp_ff, outer_kp_in;
   logic [15:0] outer_kd_ff, outer_kd_in;
   logic [15:0] inner_kp_ff, inner_kp_in;
   logic [15:0] inner_kd_ff, inner_kd_in;
   logic [15:0] inner_scale_ff, inner_scale_in;

   // loop state
   logic signed [31:0] outer_hist_ff  [3];
   logic signed [31:0] outer_hist_in  [3];
   logic signed [31:0] outer_slope_ff [2];
   logic signed [31:0] outer_slope_in [2];
   logic signed [31:0] inner_hist_ff  [3];
   logic signed [31:0] inner_hist_in  [3];
   logic signed [31:0] inner_slope_ff [2];
   logic signed [31:0] inner_slope_in [2];
   logic signed [31:0] setpoint_ff, setpoint_in;
   logic signed [31:0] prev_scaled_ff, prev_scaled_in;
   logic signed [13:0] drive_ff, drive_in;

   // sequencer and scratch
   logic [1:0]         state_ff, state_in;
   logic [3:0]         pc_ff, pc_in;
   logic               cmd_ff, cmd_in;
   logic signed [31:0] raw_ff, raw_in;
   logic [2:0]         dest_ff, dest_in;
   logic signed [31:0] s_ff, s_in;         // smoothed error (outer) or error (inner)
   logic signed [31:0] slope_ff, slope_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] v_ff, v_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [13:0] rsp_drive_ff, rsp_drive_in;
   logic signed [31:0] rsp_setp_ff, rsp_setp_in;

   ucode_type          uc;
   logic               mac_issue;
   logic signed [31:0] op_a;
   logic signed [16:0] op_b;
   mac_ctl_type        mac_ctl;
   logic               mac_res_valid;
   logic signed [31:0] mac_res;
   logic signed [13:0] drive_clamped;
   logic               rsp_free;

   assign uc        = cspd_ucode(cmd_ff, pc_ff);
   assign mac_issue = (state_ff == ST_ISSUE);
   assign mac_ctl   = '{first: uc.first, last: uc.last, shift: uc.shift};
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // operand a: history taps follow the loop being run
   always_comb begin
      case (uc.src)
         SRC_RAW:   op_a = raw_ff;
         SRC_H0:    op_a = cmd_ff ? inner_hist_ff[0] : outer_hist_ff[0];
         SRC_H1:    op_a = cmd_ff ? inner_hist_ff[1] : outer_hist_ff[1];
         SRC_H2:    op_a = cmd_ff ? inner_hist_ff[2] : outer_hist_ff[2];
         SRC_D0:    op_a = cmd_ff ? inner_slope_ff[0] : outer_slope_ff[0];
         SRC_D1:    op_a = cmd_ff ? inner_slope_ff[1] : outer_slope_ff[1];
         SRC_S:     op_a = s_ff;
         SRC_SLOPE: op_a = slope_ff;
         SRC_T:     op_a = t_ff;
         SRC_V:     op_a = v_ff;
         SRC_PREV:  op_a = prev_scaled_ff;
         SRC_SETP:  op_a = setpoint_ff;
         default:   op_a = t_ff;
      endcase
   end

   // operand b: fixed coefficient or gain, gains zero-extended
   always_comb begin
      case (uc.coef)
         CF_04:    op_b = COEF_04;
         CF_03:    op_b = COEF_03;
         CF_02:    op_b = COEF_02;
         CF_01:    op_b = COEF_01;
         CF_06:    op_b = COEF_06;
         CF_08:    op_b = COEF_08;
         CF_015:   op_b = COEF_015;
         CF_005:   op_b = COEF_005;
         CF_ONE:   op_b = COEF_ONE;
         CF_MONE:  op_b = COEF_MONE;
         CF_KP:    op_b = $signed({1'b0, cmd_ff ? inner_kp_ff : outer_kp_ff});
         CF_KD:    op_b = $signed({1'b0, cmd_ff ? inner_kd_ff : outer_kd_ff});
         CF_SCALE: op_b = $signed({1'b0, inner_scale_ff});
         default:  op_b = COEF_ONE;
      endcase
   end

   cspd_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (mac_issue),
      .op_a        (op_a),
      .op_b        (op_b),
      .issue_ctl   (mac_ctl),
      .res_valid   (mac_res_valid),
      .res_value   (mac_res)
   );

   // drive clamp to +/-6000
   always_comb begin
      if (mac_res > 32'(DRIVE_MAX)) begin
         drive_clamped = DRIVE_MAX;
      end else if (mac_res < 32'(DRIVE_MIN)) begin
         drive_clamped = DRIVE_MIN;
      end else begin
         drive_clamped = 14'(mac_res);
      end
   end

   // config writes
   always_comb begin
      outer_kp_in    = outer_kp_ff;
      outer_kd_in    = outer_kd_ff;
      inner_kp_in    = inner_kp_ff;
      inner_kd_in    = inner_kd_ff;
      inner_scale_in = inner_scale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_OUTER_KP:    outer_kp_in    = csr_wdata;
            CSR_OUTER_KD:    outer_kd_in    = csr_wdata;
            CSR_INNER_KP:    inner_kp_in    = csr_wdata;
            CSR_INNER_KD:    inner_kd_in    = csr_wdata;
            CSR_INNER_SCALE: inner_scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and datapath writes
   always_comb begin
      state_in       = state_ff;
      pc_in          = pc_ff;
      cmd_in         = cmd_ff;
      raw_in         = raw_ff;
      dest_in        = dest_ff;
      s_in           = s_ff;
      slope_in       = slope_ff;
      t_in           = t_ff;
      v_in           = v_ff;
      outer_hist_in  = outer_hist_ff;
      outer_slope_in = outer_slope_ff;
      inner_hist_in  = inner_hist_ff;
      inner_slope_in = inner_slope_ff;
      setpoint_in    = setpoint_ff;
      prev_scaled_in = prev_scaled_ff;
      drive_in       = drive_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_drive_in   = rsp_drive_ff;
      rsp_setp_in    = rsp_setp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // the unused field is ignored; raw is the chosen input in Q form
               cmd_in   = req_command;
               raw_in   = req_command ? (32'(req_yaw_rate) <<< FRAC_BITS)
                                      : (32'(req_line_error) <<< FRAC_BITS);
               pc_in    = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            pc_in = pc_ff + 4'd1;
            if (uc.last) begin
               dest_in  = uc.dest;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_res_valid) begin
               state_in = ST_ISSUE;
               case (dest_ff)
                  DST_S:     s_in     = mac_res;
                  DST_SLOPE: slope_in = mac_res;
                  DST_T:     t_in     = mac_res;
                  DST_V:     v_in     = mac_res;
                  DST_OUTER_END: begin
                     // commit outer loop: new setpoint, shift histories
                     setpoint_in       = mac_res;
                     outer_hist_in[2]  = outer_hist_ff[1];
                     outer_hist_in[1]  = outer_hist_ff[0];
                     outer_hist_in[0]  = s_ff;
                     outer_slope_in[1] = outer_slope_ff[0];
                     outer_slope_in[0] = slope_ff;
                     state_in          = ST_DONE;
                  end
                  DST_INNER_END: begin
                     // commit inner loop: new drive, keep unblended output
                     drive_in          = drive_clamped;
                     prev_scaled_in    = v_ff;
                     inner_hist_in[2]  = inner_hist_ff[1];
                     inner_hist_in[1]  = inner_hist_ff[0];
                     inner_hist_in[0]  = s_ff;
                     inner_slope_in[1] = inner_slope_ff[0];
                     inner_slope_in[0] = slope_ff;
                     state_in          = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_DONE: begin
            // hand over once the previous response has been transferred
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = drive_ff;
               rsp_setp_in  = setpoint_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      raw_ff       <= raw_in;
      dest_ff      <= dest_in;
      s_ff         <= s_in;
      slope_ff     <= slope_in;
      t_ff         <= t_in;
      v_ff         <= v_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_setp_ff  <= rsp_setp_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         pc_ff          <= '0;
         cmd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         outer_kp_ff    <= 16'd819;
         outer_kd_ff    <= 16'd307;
         inner_kp_ff    <= 16'd819;
         inner_kd_ff    <= 16'd205;
         inner_scale_ff <= 16'd256;
         outer_hist_ff  <= '{default: '0};
         outer_slope_ff <= '{default: '0};
         inner_hist_ff  <= '{default: '0};
         inner_slope_ff <= '{default: '0};
         setpoint_ff    <= '0;
         prev_scaled_ff <= '0;
         drive_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         pc_ff          <= pc_in;
         cmd_ff         <= cmd_in;
         rsp_valid_ff   <= rsp_valid_in;
         outer_kp_ff    <= outer_kp_in;
         outer_kd_ff    <= outer_kd_in;
         inner_kp_ff    <= inner_kp_in;
         inner_kd_ff    <= inner_kd_in;
         inner_scale_ff <= inner_scale_in;
         outer_hist_ff  <= outer_hist_in;
         outer_slope_ff <= outer_slope_in;
         inner_hist_ff  <= inner_hist_in;
         inner_slope_ff <= inner_slope_in;
         setpoint_ff    <= setpoint_in;
         prev_scaled_ff <= prev_scaled_in;
         drive_ff       <= drive_in;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_steer_drive  = rsp_drive_ff;
   assign rsp_yaw_setpoint = rsp_setp_ff;

   // a finished sum only arrives while the sequencer waits for it
   a_res_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_res_valid |-> (state_ff == ST_WAIT))
      else $error("mac result outside wait state");

   // a finished sum follows the last term of its group by the pipeline depth
   a_res_latency: assert property (@(posedge clock) disable iff (reset)
      mac_res_valid |-> $past(mac_issue && uc.last, 3))
      else $error("mac result without matching last term");

   // committed drive never leaves the clamp range
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      (drive_ff <= DRIVE_MAX) && (drive_ff >= DRIVE_MIN))
      else $error("drive out of range");

endmodule

// ----- rtl/cspd_mac.sv -----
module cspd_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      issue_valid,
   input  logic signed [31:0]        op_a,
   input  logic signed [16:0]        op_b,
   input  cspd_pkg::mac_ctl_type     issue_ctl,
   output logic                      res_valid,
   output logic signed [31:0]        res_value
);
   import cspd_pkg::*;

   localparam logic signed [ACC_W-1:0] HALF_FRAC = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] HALF_GAIN = ACC_W'(1) <<< (GAIN_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO    = ACC_W'(-64'sh0000_0000_8000_0000);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     vld1_ff, vld1_in;
   mac_ctl_type              ctl1_ff, ctl1_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     vld2_ff, vld2_in;
   mac_ctl_type              ctl2_ff, ctl2_in;
   logic signed [31:0]       res_ff, res_in;
   logic                     res_vld_ff, res_vld_in;

   logic signed [ACC_W-1:0]  rounded;
   logic signed [ACC_W-1:0]  shifted;

   // stage 1: product
   always_comb begin
      prod_in = PROD_W'(op_a * op_b);
      vld1_in = issue_valid;
      ctl1_in = issue_ctl;
   end

   // stage 2: accumulate
   always_comb begin
      acc_in = acc_ff;
      if (vld1_ff) begin
         acc_in = (ctl1_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
      end
      vld2_in = vld1_ff;
      ctl2_in = ctl1_ff;
   end

   // stage 3: round to nearest, halves up, then saturate to 32 bits
   always_comb begin
      case (ctl2_ff.shift)
         SH_FRAC: begin
            rounded = acc_ff + HALF_FRAC;
            shifted = rounded >>> FRAC_BITS;
         end
         SH_GAIN: begin
            rounded = acc_ff + HALF_GAIN;
            shifted = rounded >>> GAIN_BITS;
         end
         default: begin
            rounded = acc_ff;
            shifted = acc_ff;
         end
      endcase
      if (shifted > SAT_HI) begin
         res_in = 32'sh7FFF_FFFF;
      end else if (shifted < SAT_LO) begin
         res_in = -32'sh8000_0000;
      end else begin
         res_in = 32'(shifted);
      end
      res_vld_in = vld2_ff && ctl2_ff.last;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ctl1_ff <= ctl1_in;
      acc_ff  <= acc_in;
      ctl2_ff <= ctl2_in;
      res_ff  <= res_in;
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         vld1_ff    <= vld1_in;
         vld2_ff    <= vld2_in;
         res_vld_ff <= res_vld_in;
      end
   end

   assign res_valid = res_vld_ff;
   assign res_value = res_ff;

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
   import cspd_pkg::*;

   // command codes carried in req_command
   localparam logic CMD_LINE = 1'b0;
   localparam logic CMD_YAW  = 1'b1;

   // Q.8 filter coefficients, round(c * 2^FRAC_BITS) with halves up
   localparam longint K_04  = ((2 << FRAC_BITS) + 2) / 5;
   localparam longint K_03  = ((3 << FRAC_BITS) + 5) / 10;
   localparam longint K_02  = ((1 << FRAC_BITS) + 2) / 5;
   localparam longint K_01  = ((1 << FRAC_BITS) + 5) / 10;
   localparam longint K_06  = ((3 << FRAC_BITS) + 2) / 5;
   localparam longint K_08  = ((4 << FRAC_BITS) + 2) / 5;
   localparam longint K_015 = ((3 << FRAC_BITS) + 10) / 20;
   localparam longint K_005 = ((1 << FRAC_BITS) + 10) / 20;

   localparam longint DRIVE_LIMIT = 6000;

   // run shape
   localparam int GAIN_PHASES     = 8;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int MAX_GAP         = 12;
   localparam int LONG_HOLD       = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int TIMEOUT_CYCLES  = 800000;

   typedef struct {
      logic signed [13:0] drive;
      logic signed [31:0] setpoint;
   } steer_result_type;

   typedef struct {
      logic               cmd;
      logic signed [15:0] line_error;
      logic signed [15:0] yaw_rate;
      bit                 known;
      logic signed [13:0] drive;
      logic signed [31:0] setpoint;
   } opening_row_type;

   // dut ports, all inputs known from time zero
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic               req_command      = CMD_LINE;
   logic signed [15:0] req_line_error   = '0;
   logic signed [15:0] req_yaw_rate     = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic signed [13:0] rsp_steer_drive;
   logic signed [31:0] rsp_yaw_setpoint;
   logic               csr_wr_en        = 1'b0;
   logic [2:0]         csr_index        = CSR_OUTER_KP;
   logic [15:0]        csr_wdata        = '0;

   // predictor copy of gains and loop state
   longint gain_outer_kp, gain_outer_kd, gain_inner_kp, gain_inner_kd, gain_inner_scale;
   int     line_smooth [3];
   int     line_slope [2];
   int     yaw_target;
   int     yaw_err_hist [3];
   int     yaw_slope [2];
   int     prev_scaled;
   int     drive_now;

   steer_result_type steer_results_due [$];
   int               mismatch_count = 0;

   // idling control shared between the two sides
   bit req_gaps_on   = 1'b1;
   bit rsp_gaps_on   = 1'b1;
   bit hold_rsp_long = 1'b0;

   // directed opening: first rows come straight out of reset so their results
   // are plain to see, the rest walk the field extremes for both commands
   opening_row_type opening_rows [0:19] = '{
      '{CMD_YAW,  16'sh0000, 16'sh0000, 1'b1,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh0000, 16'sh8000, 1'b1,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'sh7fff, 16'sh8000, 1'b1,  14'sd6000, 32'sd0},
      '{CMD_YAW,  16'sh0000, 16'sh7fff, 1'b1, -14'sd6000, 32'sd0},
      '{CMD_LINE, 16'sh7fff, 16'sh8000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh7fff, 16'sh0000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh7fff, 16'sh7fff, 1'b0,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'sh8000, 16'sh0000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'sh7fff, 16'sh7fff, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh8000, 16'sh0000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh8000, 16'sh7fff, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh8000, 16'sh8000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'sh0000, 16'sh8000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'sh0000, 16'shffff, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh0001, 16'sh0000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'shffff, 16'sh0000, 1'b0,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'sh0000, 16'sh0001, 1'b0,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'sh0000, 16'shffff, 1'b0,  14'sd0,    32'sd0},
      '{CMD_LINE, 16'sh5555, 16'shaaaa, 1'b0,  14'sd0,    32'sd0},
      '{CMD_YAW,  16'shaaaa, 16'sh5555, 1'b0,  14'sd0,    32'sd0}
   };

   cascaded_steering_pd_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_line_error   (req_line_error),
      .req_yaw_rate     (req_yaw_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_steer_drive  (rsp_steer_drive),
      .rsp_yaw_setpoint (rsp_yaw_setpoint),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int sat32(input longint v);
      if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < longint'(32'sh80000000)) return 32'sh80000000;
      return int'(v);
   endfunction

   // round to nearest, halves toward +inf, then arithmetic shift
   function automatic longint round_shift(input longint v, input int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic logic [15:0] default_gain(input logic [2:0] idx);
      case (idx)
         CSR_OUTER_KP:    return 16'd819;
         CSR_OUTER_KD:    return 16'd307;
         CSR_INNER_KP:    return 16'd819;
         CSR_INNER_KD:    return 16'd205;
         CSR_INNER_SCALE: return 16'd256;
         default:         return 16'd0;
      endcase
   endfunction

   function automatic void apply_gain(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         CSR_OUTER_KP:    gain_outer_kp    = longint'(val);
         CSR_OUTER_KD:    gain_outer_kd    = longint'(val);
         CSR_INNER_KP:    gain_inner_kp    = longint'(val);
         CSR_INNER_KD:    gain_inner_kd    = longint'(val);
         CSR_INNER_SCALE: gain_inner_scale = longint'(val);
         default: ;  // unused index, write dropped
      endcase
   endfunction

   function automatic void clear_loops();
      line_smooth  = '{0, 0, 0};
      line_slope   = '{0, 0};
      yaw_err_hist = '{0, 0, 0};
      yaw_slope    = '{0, 0};
      yaw_target   = 0;
      prev_scaled  = 0;
      drive_now    = 0;
      for (int i = CSR_OUTER_KP; i <= CSR_INNER_SCALE; i++)
         apply_gain(3'(i), default_gain(3'(i)));
   endfunction

   // outer loop: smooth line error, weighted slope, pd, negate into setpoint
   function automatic void advance_line_loop(input logic signed [15:0] err);
      longint raw;
      int     s, slope, deriv;
      raw   = longint'(err) <<< FRAC_BITS;
      s     = sat32(round_shift(K_04 * raw + K_03 * line_smooth[0] + K_02 * line_smooth[1]
                                + K_01 * line_smooth[2], FRAC_BITS));
      slope = sat32(longint'(s) - line_smooth[2]);
      deriv = sat32(round_shift(K_06 * slope + K_03 * line_slope[0] + K_01 * line_slope[1],
                                FRAC_BITS));
      yaw_target = sat32(-longint'(sat32(round_shift(gain_outer_kp * s + gain_outer_kd * deriv,
                                                     GAIN_BITS))));
      line_smooth[2] = line_smooth[1];
      line_smooth[1] = line_smooth[0];
      line_smooth[0] = s;
      line_slope[1]  = line_slope[0];
      line_slope[0]  = slope;
   endfunction

   // inner loop: pd on setpoint minus yaw, scale, blend, round and clamp
   function automatic void advance_yaw_loop(input logic signed [15:0] yaw);
      int     e, slope, deriv, u, v, w;
      longint r;
      e     = sat32(longint'(yaw_target) - (longint'(yaw) <<< FRAC_BITS));
      slope = sat32(longint'(e) - yaw_err_hist[2]);
      deriv = sat32(round_shift(K_08 * slope + K_015 * yaw_slope[0] + K_005 * yaw_slope[1],
                                FRAC_BITS));
      u = sat32(round_shift(gain_inner_kp * e + gain_inner_kd * deriv, GAIN_BITS));
      v = sat32(round_shift(longint'(u) * gain_inner_scale, GAIN_BITS));
      w = sat32(round_shift(K_08 * v + K_02 * prev_scaled, FRAC_BITS));
      r = round_shift(longint'(w), FRAC_BITS);
      if (r > DRIVE_LIMIT) r = DRIVE_LIMIT;
      if (r < -DRIVE_LIMIT) r = -DRIVE_LIMIT;
      drive_now   = int'(r);
      prev_scaled = v;
      yaw_err_hist[2] = yaw_err_hist[1];
      yaw_err_hist[1] = yaw_err_hist[0];
      yaw_err_hist[0] = e;
      yaw_slope[1]    = yaw_slope[0];
      yaw_slope[0]    = slope;
   endfunction

   function automatic steer_result_type predict_steer_result(input logic cmd,
                                                             input logic signed [15:0] err,
                                                             input logic signed [15:0] yaw);
      steer_result_type res;
      if (cmd == CMD_LINE)
         advance_line_loop(err);
      else
         advance_yaw_loop(yaw);
      res.drive    = 14'(drive_now);
      res.setpoint = yaw_target;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // a mix of full range values, extremes and smaller values so that
   // not every step saturates
   function automatic logic signed [15:0] pick_field();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'(int'($urandom_range(0, 400)) - 200);
         3, 4:    return 16'(int'($urandom_range(0, 8000)) - 4000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] planned_gain(input int phase, input logic [2:0] idx);
      case (phase)
         1:       return 16'hffff;
         2:       return 16'h0000;
         4:       return (idx == CSR_OUTER_KP || idx == CSR_INNER_KP) ? 16'hffff :
                         (idx == CSR_INNER_SCALE) ? 16'h0100 : 16'h0000;
         5:       return 16'($urandom_range(0, 1024));
         6:       return default_gain(idx);
         default: return 16'($urandom);
      endcase
   endfunction

   // one write per cycle; the model takes it at the same edge as the block
   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_gain(idx, val);
   endtask

   // offer one request and hold it until the transfer; valid is left high
   // so a zero gap on the next item does not drop it
   task automatic offer_request(input logic cmd, input logic signed [15:0] err,
                                input logic signed [15:0] yaw);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_line_error <= err;
      req_yaw_rate   <= yaw;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (steer_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_items(input int phase);
      logic               cmd;
      logic signed [15:0] err, yaw;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
         // the block fills up behind a receiver that stops taking results
         if (phase == 1 && n == 40) hold_rsp_long = 1'b1;
         cmd = 1'($urandom_range(0, 1));
         err = pick_field();
         yaw = pick_field();
         offer_request(cmd, err, yaw);
         steer_results_due.push_back(predict_steer_result(cmd, err, yaw));
      end
   endtask

   // main sequence: reset, directed opening, then gain phases of random items
   initial begin
      steer_result_type res;
      clear_loops();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i]) begin
         offer_request(opening_rows[i].cmd, opening_rows[i].line_error,
                       opening_rows[i].yaw_rate);
         res = predict_steer_result(opening_rows[i].cmd, opening_rows[i].line_error,
                                    opening_rows[i].yaw_rate);
         if (opening_rows[i].known) begin
            res.drive    = opening_rows[i].drive;
            res.setpoint = opening_rows[i].setpoint;
         end
         steer_results_due.push_back(res);
      end

      for (int phase = 0; phase < GAIN_PHASES; phase++) begin
         // idling mix: both sides, none, sender only, receiver only
         req_gaps_on = (phase % 4 == 0) || (phase % 4 == 2);
         rsp_gaps_on = (phase % 4 == 0) || (phase % 4 == 3);
         if (phase > 0) begin
            drain_results();
            for (int i = CSR_OUTER_KP; i <= CSR_INNER_SCALE; i++)
               write_csr(3'(i), planned_gain(phase, 3'(i)));
            // index past the last register must be ignored
            write_csr(CSR_INNER_SCALE + 3'($urandom_range(1, 3)), 16'($urandom));
            csr_wr_en <= 1'b0;
         end
         run_random_items(phase);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- checking

   // receiver: stall starts once a result shows up, so the block really waits
   initial begin
      int               stall;
      steer_result_type exp_res;
      @(negedge reset);
      forever begin
         stall = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         // transfer happened at this edge
         if (steer_results_due.size() == 0) begin
            $error("response with nothing pending: steer_drive %0d yaw_setpoint %0d",
                   rsp_steer_drive, rsp_yaw_setpoint);
            mismatch_count++;
         end else begin
            exp_res = steer_results_due.pop_front();
            if (rsp_steer_drive !== exp_res.drive) begin
               $error("steer_drive expected %0d actual %0d", exp_res.drive, rsp_steer_drive);
               mismatch_count++;
            end
            if (rsp_yaw_setpoint !== exp_res.setpoint) begin
               $error("yaw_setpoint expected %0d actual %0d", exp_res.setpoint,
                      rsp_yaw_setpoint);
               mismatch_count++;
            end
         end
      end
   end

   // hard stop if the handshakes hang
   initial begin
      #(TIMEOUT_CYCLES * 4);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cspd_pkg.sv
rtl/cspd_mac.sv
rtl/cascaded_steering_pd_controller.sv
bench/tb_top.sv
